// ===== design/gsa_pkg.sv =====
// Shared constants and codes for the generational slot allocator.
package gsa_pkg;

	// Default table geometry.
	localparam int SLOTS_DEF     = 256;
	localparam int GEN_BITS_DEF  = 16;
	localparam int WORD_BITS_DEF = 32;

	// Fixed port field widths.
	localparam int OP_W      = 2;
	localparam int ST_W      = 2;
	localparam int HIDX_W    = 8;
	localparam int HGEN_W    = 16;
	localparam int PAYLOAD_W = 32;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK           = 2'd0;
	localparam logic [ST_W-1:0] ST_NULL_PAYLOAD = 2'd1;
	localparam logic [ST_W-1:0] ST_STALE        = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL         = 2'd3;

endpackage

// ===== design/gsa_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
module gsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/generational_slot_allocator.sv =====
// Generational slot allocator: handle table with generation counters and a LIFO free list.
// Rejected items, clear and fresh allocate go straight to the result stage; lookup and
// release first read the slot RAM; allocate from the free list reads the stack RAM, then
// the slot RAM. One item at a time: the next item is taken the cycle after its result
// enters the output register, later while a result waits on out_ready.
// Reset: asynchronous; free-list depth to zero, fresh mark to one; RAM contents are kept.
module generational_slot_allocator #(
	parameter int SLOTS     = gsa_pkg::SLOTS_DEF,
	parameter int GEN_BITS  = gsa_pkg::GEN_BITS_DEF,
	parameter int WORD_BITS = gsa_pkg::WORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [gsa_pkg::OP_W-1:0]       operation,
	input  logic [gsa_pkg::HIDX_W-1:0]     handle_index,
	input  logic [gsa_pkg::HGEN_W-1:0]     handle_gen,
	input  logic [gsa_pkg::PAYLOAD_W-1:0]  payload,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gsa_pkg::ST_W-1:0]       status,
	output logic [gsa_pkg::HIDX_W-1:0]     out_index,
	output logic [gsa_pkg::HGEN_W-1:0]     out_gen,
	output logic [gsa_pkg::PAYLOAD_W-1:0]  out_payload
);

	import gsa_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef struct packed {
		logic                 live;
		logic [GEN_BITS-1:0]  gen;
		logic [WORD_BITS-1:0] word;
	} slot_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_STK  = 4'b0010,
		S_SLOT = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;

	logic [CW-1:0]        depth_q;
	logic [CW-1:0]        fresh_q;
	logic [OP_W-1:0]      op_q;
	logic [HGEN_W-1:0]    hgen_q;
	logic [WORD_BITS-1:0] word_q;
	logic [IW-1:0]        idx_q;

	logic [ST_W-1:0]      res_st_q;
	logic [IW-1:0]        res_idx_q;
	logic [GEN_BITS-1:0]  res_gen_q;
	logic [WORD_BITS-1:0] res_word_q;

	logic                 out_valid_q;
	logic [ST_W-1:0]      out_st_q;
	logic [HIDX_W-1:0]    out_idx_q;
	logic [HGEN_W-1:0]    out_gen_q;
	logic [PAYLOAD_W-1:0] out_word_q;

	// Memory ports.
	logic          slot_we, slot_re;
	logic [IW-1:0] slot_waddr, slot_raddr;
	slot_t         slot_wdata, slot_rdata;
	logic          stk_we, stk_re;
	logic [IW-1:0] stk_waddr, stk_raddr, stk_rdata;

	// Input decode.
	logic                 accept;
	logic [31:0]          hix_w;
	logic [63:0]          pay_w;
	logic [WORD_BITS-1:0] word_in;
	logic                 null_in, can_pop, can_fresh, handle_pre_ok, is_hdl;
	logic [CW-1:0]        depth_m1;

	assign accept    = in_valid && in_ready;
	assign hix_w     = 32'(handle_index);
	assign pay_w     = 64'(payload);
	assign word_in   = pay_w[WORD_BITS-1:0];
	assign null_in   = (word_in == '0);
	assign can_pop   = (depth_q != '0);
	assign can_fresh = (fresh_q < CW'(SLOTS));
	assign depth_m1  = depth_q - CW'(1);
	assign is_hdl    = (operation == OP_LOOKUP) || (operation == OP_RELEASE);
	// Index zero, generation zero and never-used slots are rejected before any RAM read.
	assign handle_pre_ok = (hix_w != '0) && (handle_gen != '0) && (hix_w < 32'(fresh_q));

	// Slot read-back checks.
	logic [31:0]         rd_gen_w;
	logic                hit;
	logic [GEN_BITS-1:0] alloc_gen, inc_gen;

	assign rd_gen_w  = 32'(slot_rdata.gen);
	assign hit       = slot_rdata.live && (rd_gen_w == 32'(hgen_q));
	assign alloc_gen = (slot_rdata.gen == '0) ? GEN_BITS'(1) : slot_rdata.gen;
	always_comb begin
		inc_gen = slot_rdata.gen + GEN_BITS'(1);
		if (inc_gen == '0) begin
			inc_gen = GEN_BITS'(1);
		end
	end

	// Memory control.
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = idx_q;
		slot_wdata = '0;
		slot_re    = 1'b0;
		slot_raddr = hix_w[IW-1:0];
		stk_we     = 1'b0;
		stk_waddr  = depth_q[IW-1:0];
		stk_re     = 1'b0;
		stk_raddr  = depth_m1[IW-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept && operation == OP_ALLOC && !null_in) begin
					if (can_pop) begin
						stk_re = 1'b1;
					end else if (can_fresh) begin
						slot_we    = 1'b1;
						slot_waddr = fresh_q[IW-1:0];
						slot_wdata = '{live: 1'b1, gen: GEN_BITS'(1), word: word_in};
					end
				end
				if (accept && is_hdl && handle_pre_ok) begin
					slot_re = 1'b1;
				end
			end
			S_STK: begin
				slot_re    = 1'b1;
				slot_raddr = stk_rdata;
			end
			S_SLOT: begin
				if (op_q == OP_ALLOC) begin
					slot_we    = 1'b1;
					slot_wdata = '{live: 1'b1, gen: alloc_gen, word: word_q};
				end else if (op_q == OP_RELEASE && hit) begin
					slot_we    = 1'b1;
					slot_wdata = '{live: 1'b0, gen: inc_gen, word: '0};
					stk_we     = (depth_q < CW'(SLOTS));
				end
			end
			default: begin
			end
		endcase
	end

	gsa_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	gsa_ram #(
		.WIDTH (IW),
		.DEPTH (SLOTS)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (idx_q),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign in_ready = (state_q == S_IDLE);

	logic out_load;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Sequencer and table pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
			fresh_q <= CW'(1);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DONE;
						case (operation)
							OP_ALLOC: begin
								if (!null_in) begin
									if (can_pop) begin
										depth_q <= depth_m1;
										state_q <= S_STK;
									end else if (can_fresh) begin
										fresh_q <= fresh_q + CW'(1);
									end
								end
							end
							OP_LOOKUP, OP_RELEASE: begin
								if (handle_pre_ok) begin
									state_q <= S_SLOT;
								end
							end
							OP_CLEAR: begin
								depth_q <= '0;
								fresh_q <= CW'(1);
							end
							default: begin
							end
						endcase
					end
				end
				S_STK: begin
					state_q <= S_SLOT;
				end
				S_SLOT: begin
					if (op_q == OP_RELEASE && hit && depth_q < CW'(SLOTS)) begin
						depth_q <= depth_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item capture and result assembly.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q       <= operation;
					hgen_q     <= handle_gen;
					word_q     <= word_in;
					idx_q      <= hix_w[IW-1:0];
					res_st_q   <= ST_OK;
					res_idx_q  <= '0;
					res_gen_q  <= '0;
					res_word_q <= '0;
					if (operation == OP_ALLOC) begin
						if (null_in) begin
							res_st_q <= ST_NULL_PAYLOAD;
						end else if (!can_pop && can_fresh) begin
							res_idx_q <= fresh_q[IW-1:0];
							res_gen_q <= GEN_BITS'(1);
						end else if (!can_pop) begin
							res_st_q <= ST_FULL;
						end
					end else if (is_hdl && !handle_pre_ok) begin
						res_st_q <= ST_STALE;
					end
				end
			end
			S_STK: begin
				idx_q <= stk_rdata;
			end
			S_SLOT: begin
				if (op_q == OP_ALLOC) begin
					res_idx_q <= idx_q;
					res_gen_q <= alloc_gen;
				end else if (hit) begin
					res_word_q <= slot_rdata.word;
				end else begin
					res_st_q <= ST_STALE;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	logic [31:0] res_idx_w, res_gen_w;
	logic [63:0] res_word_w;
	assign res_idx_w  = 32'(res_idx_q);
	assign res_gen_w  = 32'(res_gen_q);
	assign res_word_w = 64'(res_word_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_st_q   <= res_st_q;
			out_idx_q  <= res_idx_w[HIDX_W-1:0];
			out_gen_q  <= res_gen_w[HGEN_W-1:0];
			out_word_q <= res_word_w[PAYLOAD_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_st_q;
	assign out_index   = out_idx_q;
	assign out_gen     = out_gen_q;
	assign out_payload = out_word_q;

endmodule
